// ----- rtl/pcm_gm_pkg.sv -----
// Shared constants and types for the PCM gain mixer.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package pcm_gm_pkg;

	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;
	localparam int GAIN_INT_BITS      = 8;

	// 1/sqrt(2) in Q0.16, used for mono to stereo spreading
	localparam int                    SCALE_BITS    = 16;
	localparam logic [SCALE_BITS-1:0] INV_SQRT2_Q16 = 16'd46341;

	localparam int CLIP_W = 32;

	// config register indexes
	localparam int              CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_CH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH = 2'd2;

	localparam int              CH_W      = 2;
	localparam logic [CH_W-1:0] CH_MONO   = 2'd1;
	localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

	typedef struct packed {
		logic scaled;   // apply 1/sqrt(2)
		logic active;   // lane produces a real sample
	} lane_ctrl_t;

endpackage

// ----- rtl/pcm_gain_mixer_saturating_core.sv -----
// PCM gain mixer top level: config registers, mode decode, two lanes, merge.
// Depends on pcm_gm_pkg, pcm_gm_lane, pcm_gm_merge.
// Pipeline: 4 lane stages + output reg between input acceptance and m_tvalid.
// Throughput: one word per cycle; the whole pipe stalls while m_tvalid waits on m_tready.
// Lane stages: input register, gain multiply, 1/sqrt(2) multiply, round and saturate, each registered.
// Reset (arst_n low, async): pipe empty, clip counter 0, gain 1.0, stereo in and out.
`timescale 1ns / 1ps

module pcm_gain_mixer_saturating_core #(
	parameter int SAMPLE_BITS    = pcm_gm_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pcm_gm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// config write port, no read-back
	input  logic                                              cfg_we,
	input  logic [pcm_gm_pkg::CFG_IDX_W-1:0]                  cfg_index,
	input  logic [pcm_gm_pkg::GAIN_INT_BITS+GAIN_FRAC_BITS-1:0] cfg_data,

	// input word, low bits up: src_left, src_right, dst_left, dst_right, zero pad
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,

	// output word, low bits up: mix_left, mix_right, clip_left, clip_right,
	// clip_total, zero pad
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((2*SAMPLE_BITS+2+pcm_gm_pkg::CLIP_W+7)/8)*8-1:0] m_tdata
);

	localparam int GW = pcm_gm_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int CHW = pcm_gm_pkg::CH_W;

	// config registers
	logic [GW-1:0]  gain_q;
	logic [CHW-1:0] in_ch_q;
	logic [CHW-1:0] out_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GW'(1) << GAIN_FRAC_BITS;
			in_ch_q  <= pcm_gm_pkg::CH_STEREO;
			out_ch_q <= pcm_gm_pkg::CH_STEREO;
		end else if (cfg_we) begin
			case (cfg_index)
				pcm_gm_pkg::CFG_GAIN:   gain_q   <= cfg_data;
				pcm_gm_pkg::CFG_IN_CH:  in_ch_q  <= cfg_data[CHW-1:0];
				pcm_gm_pkg::CFG_OUT_CH: out_ch_q <= cfg_data[CHW-1:0];
				default: ;
			endcase
		end
	end

	// unpack input word
	logic signed [SB-1:0] sl, sr, dl, dr;
	assign sl = s_tdata[SB-1:0];
	assign sr = s_tdata[2*SB-1:SB];
	assign dl = s_tdata[3*SB-1:2*SB];
	assign dr = s_tdata[4*SB-1:3*SB];

	// mode decode: code 1 is mono, anything else stereo
	logic src_mono, dst_mono;
	assign src_mono = (in_ch_q == pcm_gm_pkg::CH_MONO);
	assign dst_mono = (out_ch_q == pcm_gm_pkg::CH_MONO);

	// stereo to mono average, truncated toward zero
	logic signed [SB:0]   lr_sum;
	logic signed [SB:0]   lr_adj;
	logic signed [SB-1:0] avg;
	always_comb begin
		lr_sum = {sl[SB-1], sl} + {sr[SB-1], sr};
		lr_adj = lr_sum + {{SB{1'b0}}, lr_sum[SB] & lr_sum[0]};
		avg    = lr_adj[SB:1];
	end

	logic signed [SB-1:0]   src_l, src_r;
	pcm_gm_pkg::lane_ctrl_t ctrl_l, ctrl_r;
	always_comb begin
		src_l = (!src_mono && dst_mono) ? avg : sl;
		src_r = src_mono ? sl : sr;
		ctrl_l.scaled = src_mono && !dst_mono;
		ctrl_l.active = 1'b1;
		ctrl_r.scaled = src_mono && !dst_mono;
		ctrl_r.active = !dst_mono;
	end

	// global pipe advance: output register empty or being drained
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic v_s1, v_s2, v_s3, v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s4, v_s3, v_s2, v_s1} <= 4'b0000;
		end else if (adv) begin
			{v_s4, v_s3, v_s2, v_s1} <= {v_s3, v_s2, v_s1, s_tvalid};
		end
	end

	logic signed [SB-1:0] mix_l, mix_r;
	logic                 clip_l, clip_r;

	pcm_gm_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_lane_l (
		.clk (clk),
		.adv (adv),
		.gain(gain_q),
		.src (src_l),
		.dst (dl),
		.ctrl(ctrl_l),
		.mix (mix_l),
		.clip(clip_l)
	);

	pcm_gm_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_lane_r (
		.clk (clk),
		.adv (adv),
		.gain(gain_q),
		.src (src_r),
		.dst (dr),
		.ctrl(ctrl_r),
		.mix (mix_r),
		.clip(clip_r)
	);

	// joins lanes, counts clips, holds the output word
	pcm_gm_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_s4),
		.mix_l   (mix_l),
		.mix_r   (mix_r),
		.clip_l  (clip_l),
		.clip_r  (clip_r),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

endmodule

// ----- rtl/pcm_gm_lane.sv -----
// One mixing lane: gain multiply, optional 1/sqrt(2), round half up, saturate.
// Depends on pcm_gm_pkg.
`timescale 1ns / 1ps

module pcm_gm_lane #(
	parameter int SAMPLE_BITS    = pcm_gm_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pcm_gm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          adv,
	input  logic [pcm_gm_pkg::GAIN_INT_BITS+GAIN_FRAC_BITS-1:0] gain,
	input  logic signed [SAMPLE_BITS-1:0]                 src,
	input  logic signed [SAMPLE_BITS-1:0]                 dst,
	input  pcm_gm_pkg::lane_ctrl_t                        ctrl,
	output logic signed [SAMPLE_BITS-1:0]                 mix,
	output logic                                          clip
);

	localparam int GW  = pcm_gm_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;
	localparam int SCB = pcm_gm_pkg::SCALE_BITS;
	localparam int P1W = GW + 1 + SAMPLE_BITS;
	localparam int P2W = P1W + SCB + 1;
	localparam int AW  = P2W + 2;
	localparam int SH  = GAIN_FRAC_BITS + SCB;

	localparam logic signed [AW-1:0] HALF = AW'(1) << (SH - 1);
	localparam logic signed [AW-1:0] SMAX = AW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [AW-1:0] SMIN = ~SMAX;

	logic signed [SAMPLE_BITS-1:0] src_s1, dst_s1, dst_s2, dst_s3;
	pcm_gm_pkg::lane_ctrl_t        ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [P1W-1:0]         p1_s2;
	logic signed [P2W-1:0]         p2_s3;
	logic signed [P2W-1:0]         p2_d;
	logic signed [AW-1:0]          acc_d, q_d;
	logic signed [SAMPLE_BITS-1:0] mix_s4;
	logic                          clip_s4;
	logic signed [SAMPLE_BITS-1:0] mix_d;
	logic                          clip_d;

	// both paths end up in Q.(GAIN_FRAC_BITS+16) so one rounder serves
	always_comb begin
		if (ctrl_s2.scaled) begin
			p2_d = p1_s2 * $signed({1'b0, pcm_gm_pkg::INV_SQRT2_Q16});
		end else begin
			p2_d = {p1_s2[P1W-1], p1_s2, {SCB{1'b0}}};
		end
	end

	always_comb begin
		acc_d = ({{(AW-SAMPLE_BITS){dst_s3[SAMPLE_BITS-1]}}, dst_s3} <<< SH)
		      + {{2{p2_s3[P2W-1]}}, p2_s3} + HALF;
		q_d   = acc_d >>> SH;    // floor
		mix_d  = q_d[SAMPLE_BITS-1:0];
		clip_d = 1'b0;
		if (q_d > SMAX) begin
			mix_d  = SMAX[SAMPLE_BITS-1:0];
			clip_d = 1'b1;
		end else if (q_d < SMIN) begin
			mix_d  = SMIN[SAMPLE_BITS-1:0];
			clip_d = 1'b1;
		end
		if (!ctrl_s3.active) begin
			mix_d  = '0;
			clip_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1  <= src;
			dst_s1  <= dst;
			ctrl_s1 <= ctrl;
			p1_s2   <= $signed({1'b0, gain}) * src_s1;
			dst_s2  <= dst_s1;
			ctrl_s2 <= ctrl_s1;
			p2_s3   <= p2_d;
			dst_s3  <= dst_s2;
			ctrl_s3 <= ctrl_s2;
			mix_s4  <= mix_d;
			clip_s4 <= clip_d;
		end
	end

	assign mix  = mix_s4;
	assign clip = clip_s4;

endmodule

// ----- rtl/pcm_gm_merge.sv -----
// Merge stage: joins both lanes, keeps the saturating clip counter, output register.
// Depends on pcm_gm_pkg.
`timescale 1ns / 1ps

module pcm_gm_merge #(
	parameter int SAMPLE_BITS = pcm_gm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  v_in,
	input  logic signed [SAMPLE_BITS-1:0]         mix_l,
	input  logic signed [SAMPLE_BITS-1:0]         mix_r,
	input  logic                                  clip_l,
	input  logic                                  clip_r,
	output logic                                  m_tvalid,
	output logic [((2*SAMPLE_BITS+2+pcm_gm_pkg::CLIP_W+7)/8)*8-1:0] m_tdata
);

	localparam int CW    = pcm_gm_pkg::CLIP_W;
	localparam int OUT_W = ((2*SAMPLE_BITS + 2 + CW + 7) / 8) * 8;

	logic [CW-1:0]          cnt_q;
	logic [CW+1:0]          cnt_sum;
	logic [CW-1:0]          cnt_next;
	logic                   tvalid_q;
	logic [SAMPLE_BITS-1:0] ml_q, mr_q;
	logic                   cl_q, cr_q;

	always_comb begin
		cnt_sum  = {2'b00, cnt_q} + {{(CW+1){1'b0}}, clip_l} + {{(CW+1){1'b0}}, clip_r};
		cnt_next = (cnt_sum[CW+1:CW] != 2'b00) ? {CW{1'b1}} : cnt_sum[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tvalid_q <= 1'b0;
		end else if (adv) begin
			tvalid_q <= v_in;
			if (v_in) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_in) begin
			ml_q <= mix_l;
			mr_q <= mix_r;
			cl_q <= clip_l;
			cr_q <= clip_r;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = OUT_W'({cnt_q, cr_q, cl_q, mr_q, ml_q});

`ifndef ASSERT_OFF
	// counter never goes backwards
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("clip counter decreased");
	// at most two clipped samples per word
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q - $past(cnt_q)) <= CW'(2))
		else $error("clip counter jumped by more than two");
	// counter moves only when a word is loaded
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && v_in) |=> $stable(cnt_q))
		else $error("clip counter changed without a word");
`endif

endmodule
